// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check prop at every clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check prop at every clock edge, reset included
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(name, prop, msg)
`define ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ===== sv/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Widths, branch codes and pipeline carry types of the matrix-to-quaternion unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rmq_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = WORD_WIDTH - 2;
    localparam int ARG_WIDTH  = WORD_WIDTH + 2;
    localparam int DIFF_WIDTH = WORD_WIDTH + 1;
    localparam int NUM_WIDTH  = 2 * WORD_WIDTH;
    localparam int ROOT_WIDTH = WORD_WIDTH;
    localparam int LANES      = 3;

    // which component comes from the root itself
    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_Z,
        SEL_W
    } sel_t;

    typedef logic signed [DIFF_WIDTH-1:0] diff_t;

    typedef struct packed {
        logic              bad;
        sel_t              sel;
        diff_t [LANES-1:0] d;
    } sq_carry_t;

    typedef struct packed {
        logic                  bad;
        sel_t                  sel;
        logic [ROOT_WIDTH-1:0] root;
        logic [LANES-1:0]      neg;
        logic [LANES-1:0]      big;
    } dv_carry_t;

endpackage
`default_nettype wire

// ===== sv/rotation_matrix_to_quaternion_unit.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Pipelined Shepperd conversion of a Q2.30 rotation matrix to a quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: the nine matrix elements r00..r22 (signed Q2.30) with
//   in_valid / in_stall. A beat moves when in_valid is high and in_stall low.
//   Output channel: quat_x, quat_y, quat_z, quat_w (signed Q2.30, saturated)
//   and bad_input with out_valid / out_stall, same beat rule.
//   Stages: two setup stages, 32 square-root stages (one root bit each),
//   one divider setup stage, 32 divider stages (one quotient bit each,
//   three lanes side by side) and the output register.
//   Throughput: one beat per cycle while out_stall does not hold the
//   pipeline; every stage is registered and no loop feeds back, so a new
//   matrix may enter on every clock that in_stall is low.
//   Stall: when the output register holds a beat and out_stall is high, the
//   whole pipeline holds and in_stall rises in the same cycle; nothing is
//   dropped or repeated, and it resumes the cycle out_stall falls.
//   Reset: rst_n clears every valid bit at once; the block takes a beat in
//   the first cycle after release. A root argument that is not positive
//   gives all-zero components with bad_input set.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rotation_matrix_to_quaternion_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] r00,
    input  wire logic signed [31:0] r01,
    input  wire logic signed [31:0] r02,
    input  wire logic signed [31:0] r10,
    input  wire logic signed [31:0] r11,
    input  wire logic signed [31:0] r12,
    input  wire logic signed [31:0] r20,
    input  wire logic signed [31:0] r21,
    input  wire logic signed [31:0] r22,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      quat_x,
    output logic signed [31:0]      quat_y,
    output logic signed [31:0]      quat_z,
    output logic signed [31:0]      quat_w,
    output logic                    bad_input
);

    localparam int W  = rmq_pkg::WORD_WIDTH;
    localparam int F  = rmq_pkg::FRAC_BITS;
    localparam int AW = rmq_pkg::ARG_WIDTH;
    localparam int DW = rmq_pkg::DIFF_WIDTH;
    localparam int NW = rmq_pkg::NUM_WIDTH;
    localparam int RW = rmq_pkg::ROOT_WIDTH;
    localparam int L  = rmq_pkg::LANES;

    localparam logic signed [AW-1:0] ONE_Q = {{(AW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [W-1:0]  MAX_Q = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  MIN_Q = {1'b1, {(W-1){1'b0}}};

    // Global advance: hold everything while the output beat waits.
    logic adv;
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // ------------------------------------------------------------------
    // Stage 1: trace, the four root arguments, off-diagonal sums and
    // differences, diagonal compares.
    // ------------------------------------------------------------------
    logic signed [AW-1:0] e00, e11, e22, tr_c;
    logic signed [AW-1:0] arg_w_c, arg_x_c, arg_y_c, arg_z_c;
    logic signed [DW-1:0] da_c, db_c, dc_c, de_c, df_c, dg_c;

    always_comb
    begin
        e00     = AW'(r00);
        e11     = AW'(r11);
        e22     = AW'(r22);
        tr_c    = e00 + e11 + e22;
        arg_w_c = tr_c + ONE_Q;
        arg_x_c = e00 - (e11 + e22) + ONE_Q;
        arg_y_c = e11 - (e22 + e00) + ONE_Q;
        arg_z_c = e22 - (e00 + e11) + ONE_Q;
        da_c    = DW'(r21) - DW'(r12);
        db_c    = DW'(r02) - DW'(r20);
        dc_c    = DW'(r10) - DW'(r01);
        de_c    = DW'(r01) + DW'(r10);
        df_c    = DW'(r20) + DW'(r02);
        dg_c    = DW'(r12) + DW'(r21);
    end

    logic                 s1_valid_reg;
    logic                 s1_tr_neg_reg, s1_ge01_reg, s1_ge02_reg, s1_ge12_reg;
    logic signed [AW-1:0] s1_arg_w_reg, s1_arg_x_reg, s1_arg_y_reg, s1_arg_z_reg;
    logic signed [DW-1:0] s1_da_reg, s1_db_reg, s1_dc_reg, s1_de_reg, s1_df_reg, s1_dg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tr_neg_reg <= tr_c[AW-1];
            s1_ge01_reg   <= (r00 >= r11);
            s1_ge02_reg   <= (r00 >= r22);
            s1_ge12_reg   <= (r11 >= r22);
            s1_arg_w_reg  <= arg_w_c;
            s1_arg_x_reg  <= arg_x_c;
            s1_arg_y_reg  <= arg_y_c;
            s1_arg_z_reg  <= arg_z_c;
            s1_da_reg     <= da_c;
            s1_db_reg     <= db_c;
            s1_dc_reg     <= dc_c;
            s1_de_reg     <= de_c;
            s1_df_reg     <= df_c;
            s1_dg_reg     <= dg_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pick the branch, its root argument and the three lane
    // operands. Lanes hold the non-picked components in x, y, z, w order.
    // ------------------------------------------------------------------
    rmq_pkg::sel_t        sel_c;
    logic signed [AW-1:0] arg_c;
    rmq_pkg::sq_carry_t   sq_carry_next;
    logic [NW-1:0]        sq_num_next;

    always_comb
    begin
        if (!s1_tr_neg_reg)
            sel_c = rmq_pkg::SEL_W;
        else if (s1_ge01_reg && s1_ge02_reg)
            sel_c = rmq_pkg::SEL_X;
        else if (s1_ge12_reg)
            sel_c = rmq_pkg::SEL_Y;
        else
            sel_c = rmq_pkg::SEL_Z;

        sq_carry_next.sel = sel_c;
        case (sel_c)
            rmq_pkg::SEL_X:
            begin
                arg_c               = s1_arg_x_reg;
                sq_carry_next.d[0]  = s1_de_reg;
                sq_carry_next.d[1]  = s1_df_reg;
                sq_carry_next.d[2]  = s1_da_reg;
            end
            rmq_pkg::SEL_Y:
            begin
                arg_c               = s1_arg_y_reg;
                sq_carry_next.d[0]  = s1_de_reg;
                sq_carry_next.d[1]  = s1_dg_reg;
                sq_carry_next.d[2]  = s1_db_reg;
            end
            rmq_pkg::SEL_Z:
            begin
                arg_c               = s1_arg_z_reg;
                sq_carry_next.d[0]  = s1_df_reg;
                sq_carry_next.d[1]  = s1_dg_reg;
                sq_carry_next.d[2]  = s1_dc_reg;
            end
            default:
            begin
                arg_c               = s1_arg_w_reg;
                sq_carry_next.d[0]  = s1_da_reg;
                sq_carry_next.d[1]  = s1_db_reg;
                sq_carry_next.d[2]  = s1_dc_reg;
            end
        endcase

        // argument not above zero: flag it, the root path runs on don't-care
        sq_carry_next.bad = arg_c[AW-1] || (arg_c == '0);
        sq_num_next       = NW'({arg_c[W:0], {F{1'b0}}});
    end

    // ------------------------------------------------------------------
    // Square root: one result bit per stage, index 0 is the stage 2 register.
    // ------------------------------------------------------------------
    logic               sq_v_reg [0:RW];
    logic [NW-1:0]      sq_n_reg [0:RW];
    logic [NW-1:0]      sq_r_reg [0:RW];
    rmq_pkg::sq_carry_t sq_c_reg [0:RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_v_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_n_reg[0] <= sq_num_next;
            sq_r_reg[0] <= '0;
            sq_c_reg[0] <= sq_carry_next;
        end
    end

    for (genvar k = 0; k < RW; k++)
    begin : g_sq
        localparam logic [NW-1:0] BIT_K = NW'(1) << (NW - 2 - 2 * k);
        logic [NW-1:0] trial;
        logic [NW-1:0] n_next;
        logic [NW-1:0] r_next;

        always_comb
        begin
            trial = sq_r_reg[k] + BIT_K;
            if (sq_n_reg[k] >= trial)
            begin
                n_next = sq_n_reg[k] - trial;
                r_next = (sq_r_reg[k] >> 1) + BIT_K;
            end
            else
            begin
                n_next = sq_n_reg[k];
                r_next = sq_r_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_n_reg[k+1] <= n_next;
                sq_r_reg[k+1] <= r_next;
                sq_c_reg[k+1] <= sq_c_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider setup: magnitude, rounding bias, divisor 2*root, and the
    // overflow test (quotient would not fit in W bits).
    // ------------------------------------------------------------------
    logic [RW-1:0]      root_c;
    logic [RW:0]        dvsr_c;
    logic [NW-1:0]      numer_c [0:L-1];
    rmq_pkg::dv_carry_t dv_carry_next;

    assign root_c = sq_r_reg[RW][RW-1:0];
    assign dvsr_c = {root_c, 1'b0};

    for (genvar l = 0; l < L; l++)
    begin : g_prep
        logic signed [DW-1:0] d_l;
        logic [DW-1:0]        mag_l;

        always_comb
        begin
            d_l        = $signed(sq_c_reg[RW].d[l]);
            mag_l      = d_l[DW-1] ? DW'(-d_l) : DW'(d_l);
            numer_c[l] = NW'({mag_l, {F{1'b0}}}) + NW'(root_c);
        end

        assign dv_carry_next.neg[l] = d_l[DW-1];
        assign dv_carry_next.big[l] = {1'b0, numer_c[l]} >= {dvsr_c, {W{1'b0}}};
    end

    assign dv_carry_next.bad  = sq_c_reg[RW].bad;
    assign dv_carry_next.sel  = sq_c_reg[RW].sel;
    assign dv_carry_next.root = root_c;

    // ------------------------------------------------------------------
    // Restoring division, one quotient bit per stage in each lane.
    // ------------------------------------------------------------------
    logic               dv_v_reg    [0:W];
    logic [RW:0]        dv_dvsr_reg [0:W];
    rmq_pkg::dv_carry_t dv_c_reg    [0:W];
    logic [NW-1:0]      dv_rem_reg  [0:L-1][0:W];
    logic [W-1:0]       dv_q_reg    [0:L-1][0:W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_v_reg[0] <= sq_v_reg[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_dvsr_reg[0] <= dvsr_c;
            dv_c_reg[0]    <= dv_carry_next;
        end
    end

    for (genvar l = 0; l < L; l++)
    begin : g_lane_in
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[l][0] <= numer_c[l];
                dv_q_reg[l][0]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < W; j++)
    begin : g_dv
        localparam int B = W - 1 - j;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_dvsr_reg[j+1] <= dv_dvsr_reg[j];
                dv_c_reg[j+1]    <= dv_c_reg[j];
            end
        end

        for (genvar l = 0; l < L; l++)
        begin : g_lane
            logic [NW-1:0] shifted;
            logic [NW-1:0] rem_next;
            logic [W-1:0]  q_next;

            always_comb
            begin
                shifted = NW'(dv_dvsr_reg[j]) << B;
                if (dv_rem_reg[l][j] >= shifted)
                begin
                    rem_next = dv_rem_reg[l][j] - shifted;
                    q_next   = dv_q_reg[l][j] | (W'(1) << B);
                end
                else
                begin
                    rem_next = dv_rem_reg[l][j];
                    q_next   = dv_q_reg[l][j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_rem_reg[l][j+1] <= rem_next;
                    dv_q_reg[l][j+1]   <= q_next;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: sign and saturate each lane, half the root for the picked
    // component, route lanes to x, y, z, w, zero everything on bad input.
    // ------------------------------------------------------------------
    logic signed [W-1:0] lane_c [0:L-1];
    logic [RW:0]         root_inc;
    logic signed [W-1:0] half_c;
    logic signed [W-1:0] qx_next, qy_next, qz_next, qw_next;

    for (genvar l = 0; l < L; l++)
    begin : g_sat
        logic [W-1:0] q_l;
        logic         big_l;

        always_comb
        begin
            q_l   = dv_q_reg[l][W];
            big_l = dv_c_reg[W].big[l];
            if (!dv_c_reg[W].neg[l])
                lane_c[l] = (big_l || q_l[W-1]) ? MAX_Q : $signed(q_l);
            else if (big_l || (q_l[W-1] && (q_l[W-2:0] != '0)))
                lane_c[l] = MIN_Q;
            else
                lane_c[l] = $signed(W'(-q_l));
        end
    end

    always_comb
    begin
        root_inc = (RW+1)'(dv_c_reg[W].root) + (RW+1)'(1);
        half_c   = $signed(W'(root_inc[RW:1]));
        case (dv_c_reg[W].sel)
            rmq_pkg::SEL_X:
            begin
                qx_next = half_c;
                qy_next = lane_c[0];
                qz_next = lane_c[1];
                qw_next = lane_c[2];
            end
            rmq_pkg::SEL_Y:
            begin
                qx_next = lane_c[0];
                qy_next = half_c;
                qz_next = lane_c[1];
                qw_next = lane_c[2];
            end
            rmq_pkg::SEL_Z:
            begin
                qx_next = lane_c[0];
                qy_next = lane_c[1];
                qz_next = half_c;
                qw_next = lane_c[2];
            end
            default:
            begin
                qx_next = lane_c[0];
                qy_next = lane_c[1];
                qz_next = lane_c[2];
                qw_next = half_c;
            end
        endcase
        if (dv_c_reg[W].bad)
        begin
            qx_next = '0;
            qy_next = '0;
            qz_next = '0;
            qw_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= dv_v_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quat_x    <= qx_next;
            quat_y    <= qy_next;
            quat_z    <= qz_next;
            quat_w    <= qw_next;
            bad_input <= dv_c_reg[W].bad;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_bad_zero, out_valid && bad_input |-> quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0, "bad input beat carries nonzero components")
    `ASSERT_CLK(a_hold_on_stall, out_valid && out_stall |=> $stable(s1_valid_reg) && $stable(sq_v_reg[RW]) && $stable(dv_v_reg[W]), "pipeline moved while output stalled")
    `ASSERT_CLK(a_root_rem, sq_v_reg[RW] |-> sq_n_reg[RW] <= NW'({sq_r_reg[RW][RW-1:0], 1'b0}), "square root remainder above twice the root")
    `ASSERT_CLK(a_div_rem, dv_v_reg[W] && !dv_c_reg[W].bad |-> (dv_c_reg[W].big[0] || dv_rem_reg[0][W] < NW'(dv_dvsr_reg[W])) && (dv_c_reg[W].big[1] || dv_rem_reg[1][W] < NW'(dv_dvsr_reg[W])) && (dv_c_reg[W].big[2] || dv_rem_reg[2][W] < NW'(dv_dvsr_reg[W])), "divider remainder not below divisor")

endmodule
`default_nettype wire
